[sv/pes_pkg.sv]
package pes_pkg;

   localparam int MaxUsers = 16;
   localparam int IdxW     = (MaxUsers > 1) ? $clog2(MaxUsers) : 1;
   localparam int CntW     = $clog2(MaxUsers + 1);

   localparam int IdW      = 32;
   localparam int PerW     = 24;
   localparam int DueW     = 40;
   localparam int RunW     = 7;
   localparam int MaxRun   = 64;

   localparam logic [DueW-1:0] DueMax = {DueW{1'b1}};

   // request kinds carried on req_tuser
   localparam logic [1:0] ReqLoad  = 2'd0;
   localparam logic [1:0] ReqRun   = 2'd1;
   localparam logic [1:0] ReqClear = 2'd2;

   typedef struct packed {
      logic [IdW-1:0]  id;
      logic [PerW-1:0] period;
      logic [DueW-1:0] due;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

endpackage

[sv/pes_ram.sv]
module pes_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
   input  logic [Width-1:0]                         wdata,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
   output logic [Width-1:0]                         rdata_ff
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

[sv/periodic_event_scheduler.sv]
// Load and clear beats are handled in the cycle they are taken; the block is ready again next cycle.
// A run beat emits its events one at a time: each event takes one table read per
// entry through the single read port of the entry RAM, then the read latency, the
// compare drain and the due-time update, which waits for the output register.
// An empty-table run goes to the empty state and answers once the output register is free.
// Reset (synchronous, active high) empties the table and clears the drop flag.
module periodic_event_scheduler import pes_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // source_id[31:0], source_period[55:32],
                                   // emit_count[62:56], zero[63]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // event_id[31:0]
   output logic        rsp_tlast,  // last_of_run
   output logic [2:0]  rsp_tuser   // empty_error[0], dropped_flag[1],
                                   // time_saturated[2]
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StScan   = 2'd1;
   localparam logic [1:0] StUpdate = 2'd2;
   localparam logic [1:0] StEmpty  = 2'd3;

   // sequencer
   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic [RunW-1:0] remain_ff, remain_in;
   logic [CntW-1:0] issue_ff, issue_in;
   logic            rd_pend_ff, rd_pend_in;
   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;
   entry_type       best_ff, best_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [IdW-1:0]  rsp_id_ff, rsp_id_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_empty_ff, rsp_empty_in;
   logic            rsp_drop_ff, rsp_drop_in;
   logic            rsp_sat_ff, rsp_sat_in;

   // entry RAM ports
   logic            ram_we;
   logic [IdxW-1:0] ram_waddr;
   entry_type       ram_wdata;
   logic [IdxW-1:0] ram_raddr;
   logic [EntryW-1:0] ram_rdata;
   entry_type       cand;

   // request fields
   logic [IdW-1:0]  in_id;
   logic [PerW-1:0] in_period;
   logic [RunW-1:0] in_count;
   logic [RunW-1:0] run_len;

   logic            accept;
   logic            out_free;
   logic            better;
   logic [DueW:0]   due_sum;
   logic [DueW-1:0] next_due;

   pes_ram #(
      .Width (EntryW),
      .Depth (MaxUsers)
   ) u_ram (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .raddr    (ram_raddr),
      .rdata_ff (ram_rdata)
   );

   assign cand      = entry_type'(ram_rdata);
   assign in_id     = req_tdata[31:0];
   assign in_period = req_tdata[55:32];
   assign in_count  = req_tdata[62:56];
   assign run_len   = (in_count > RunW'(MaxRun)) ? RunW'(MaxRun) : in_count;

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Strict compare while scanning upward keeps the lowest index on a full tie.
   assign better = (rd_idx_ff == '0) ||
                   (cand.due < best_ff.due) ||
                   ((cand.due == best_ff.due) && (cand.id < best_ff.id));

   // Advance the winner's due time, saturating at the top of the range.
   assign due_sum  = {1'b0, best_ff.due} + {{(DueW + 1 - PerW){1'b0}}, best_ff.period};
   assign next_due = due_sum[DueW] ? DueMax : due_sum[DueW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      remain_in    = remain_ff;
      issue_in     = issue_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_sat_in   = rsp_sat_ff;

      ram_we       = 1'b0;
      ram_waddr    = best_idx_ff;
      ram_wdata    = '{id: best_ff.id, period: best_ff.period, due: next_due};
      ram_raddr    = issue_ff[IdxW-1:0];

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               case (req_tuser)
                  ReqLoad: begin
                     if (count_ff >= CntW'(MaxUsers)) begin
                        dropped_in = 1'b1;
                     end else begin
                        // append: first due time equals the period
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[IdxW-1:0];
                        ram_wdata = '{id: in_id, period: in_period,
                                      due: {{(DueW - PerW){1'b0}}, in_period}};
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  ReqClear: begin
                     count_in = '0;
                  end
                  ReqRun: begin
                     if (run_len != '0) begin
                        if (count_ff == '0) begin
                           state_in = StEmpty;
                        end else begin
                           remain_in = run_len;
                           issue_in  = '0;
                           state_in  = StScan;
                        end
                     end
                  end
                  default: begin
                     // unused kind: drop the beat
                  end
               endcase
            end
         end

         StScan: begin
            // issue one read per cycle, fold the returning entry in the next cycle
            if (issue_ff < count_ff) begin
               rd_pend_in = 1'b1;
               rd_idx_in  = issue_ff[IdxW-1:0];
               issue_in   = issue_ff + 1'b1;
            end
            if (rd_pend_ff && better) begin
               best_in     = cand;
               best_idx_in = rd_idx_ff;
            end
            if ((issue_ff == count_ff) && !rd_pend_ff) begin
               state_in = StUpdate;
            end
         end

         StUpdate: begin
            if (out_free) begin
               ram_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = best_ff.id;
               rsp_last_in  = (remain_ff == RunW'(1));
               rsp_empty_in = 1'b0;
               rsp_drop_in  = dropped_ff;
               rsp_sat_in   = (next_due == DueMax);
               remain_in    = remain_ff - 1'b1;
               issue_in     = '0;
               state_in     = (remain_ff == RunW'(1)) ? StIdle : StScan;
            end
         end

         StEmpty: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               rsp_drop_in  = dropped_ff;
               rsp_sat_in   = 1'b0;
               state_in     = StIdle;
            end
         end

         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers: no reset needed
   always_ff @(posedge clock) begin
      remain_ff    <= remain_in;
      issue_ff     <= issue_in;
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_drop_ff  <= rsp_drop_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_drop_ff, rsp_empty_ff};

endmodule

[sv/pes_checker.sv]
module pes_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // an empty-table answer is a lone, zero, unsaturated beat
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0 && rsp_tlast && !rsp_tuser[2])
      else $error("malformed empty-table beat");

   // no request produces a result in the cycle right after it is taken
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared one cycle after a request");

   // reset leaves the result channel empty
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind periodic_event_scheduler pes_checker u_pes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[bench/tb.sv]
// Bench for the periodic event scheduler. It builds its own model of the
// source table: ids, periods and 40-bit due times, the drop flag and the count.
module tb;
   import pes_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Request kind with no meaning; the block must swallow it without a result.
   localparam logic [1:0] ReqSpare   = 2'd3;
   localparam int         RandomJobs = 424;
   localparam int         FastRuns   = 8;      // back-to-back runs at the largest period
   localparam int         TailCycles = 100;
   localparam int         CycleLimit = 8_000_000;

   typedef struct {
      logic [1:0]      kind;
      logic [IdW-1:0]  id;
      logic [PerW-1:0] period;
      logic [RunW-1:0] count;
      bit              drain;   // hold this beat until every event is back
      bit              fast;    // no idling on either side while this phase runs
   } job_type;

   typedef struct {
      logic [IdW-1:0] id;
      logic           last;
      logic           empty;
      logic           dropped;
      logic           sat;
   } event_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // source_id[31:0], source_period[55:32],
                                   // emit_count[62:56], zero[63]
   logic [1:0]  req_tuser  = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // event_id[31:0]
   logic        rsp_tlast;         // last_of_run
   logic [2:0]  rsp_tuser;         // empty_error[0], dropped_flag[1],
                                   // time_saturated[2]

   periodic_event_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Source table model: mirrors what the block holds after each beat.
   // ---------------------------------------------------------------------
   logic [IdW-1:0]  tbl_id     [MaxUsers];
   logic [PerW-1:0] tbl_period [MaxUsers];
   logic [DueW-1:0] tbl_due    [MaxUsers];
   int              tbl_used = 0;
   bit              drop_seen = 1'b0;

   job_type   job_q[$];     // beats still to send
   event_type event_q[$];   // events the block still owes, oldest first
   int     job_total = 0;
   int     mismatch_count = 0;
   logic [31:0] cycle_count = '0;
   bit     fast_mode = 1'b0;

   // Quiet stretches: a quarter of the time nobody idles.
   wire calm = fast_mode || (cycle_count[11:10] == 2'b00);

   // Work out the events one accepted beat causes and queue them.
   task automatic advance_schedule(input job_type j);
      int              n;
      int              best;
      logic [DueW:0]   sum;
      event_type       ev;
      case (j.kind)
         ReqLoad: begin
            if (tbl_used >= MaxUsers) begin
               drop_seen = 1'b1;     // full table: drop the source, flag it
            end else begin
               tbl_id[tbl_used]     = j.id;
               tbl_period[tbl_used] = j.period;
               tbl_due[tbl_used]    = DueW'(j.period);
               tbl_used++;
            end
         end
         ReqClear: tbl_used = 0;     // drop flag survives a clear
         ReqRun: begin
            n = (int'(j.count) > MaxRun) ? MaxRun : int'(j.count);
            if (n == 0) begin
               // zero count: nothing owed
            end else if (tbl_used == 0) begin
               ev.id      = '0;
               ev.last    = 1'b1;
               ev.empty   = 1'b1;
               ev.dropped = drop_seen;
               ev.sat     = 1'b0;
               event_q.push_back(ev);
            end else begin
               for (int k = 0; k < n; k++) begin
                  // earliest due wins, then smallest id, then lowest slot
                  best = 0;
                  for (int i = 1; i < tbl_used; i++) begin
                     if (tbl_due[i] < tbl_due[best] ||
                         (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
                        best = i;
                  end
                  sum = {1'b0, tbl_due[best]} + (DueW+1)'(tbl_period[best]);
                  tbl_due[best] = sum[DueW] ? DueMax : sum[DueW-1:0];
                  ev.id      = tbl_id[best];
                  ev.last    = (k == n - 1);
                  ev.empty   = 1'b0;
                  ev.dropped = drop_seen;
                  ev.sat     = (tbl_due[best] == DueMax);
                  event_q.push_back(ev);
               end
            end
         end
         default: ;                  // spare kind: ignored
      endcase
   endtask

   // Gap lengths: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic logic [IdW-1:0] pick_id();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 3);          // crowd the ids for ties
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 2);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [PerW-1:0] rand_period();
      return PerW'($urandom_range(0, 24'hFF_FFFF));
   endfunction

   function automatic logic [RunW-1:0] rand_count();
      return RunW'($urandom_range(0, 127));
   endfunction

   function automatic logic [PerW-1:0] pick_period();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return {PerW{1'b1}};
         2, 3:    return PerW'($urandom_range(1, 7));   // small: many equal due times
         default: return rand_period();
      endcase
   endfunction

   function automatic logic [RunW-1:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return '0;
      if (r < 75) return RunW'($urandom_range(1, 12));
      if (r < 93) return RunW'($urandom_range(13, 64));
      return RunW'($urandom_range(65, 127));             // saturates to 64
   endfunction

   task automatic add_job(input logic [1:0] kind, input logic [IdW-1:0] id,
                          input logic [PerW-1:0] period, input logic [RunW-1:0] count,
                          input bit drain, input bit fast);
      job_type j;
      j.kind   = kind;
      j.id     = id;
      j.period = period;
      j.count  = count;
      j.drain  = drain;
      j.fast   = fast;
      job_q.push_back(j);
      if (kind != ReqSpare) job_total++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: pop a beat, hold it until taken, then maybe rest a while.
   // ---------------------------------------------------------------------
   job_type cur_job;
   int      send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_schedule(cur_job);
            fast_mode = cur_job.fast;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (job_q.size() > 0 &&
                         !(job_q[0].drain && event_q.size() > 0)) begin
               cur_job = job_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, cur_job.count, cur_job.period, cur_job.id};
               req_tuser  <= cur_job.kind;
               send_gap = calm ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: take result beats, compare each field with the oldest event.
   // ---------------------------------------------------------------------
   int hold_left = 0;

   always @(posedge clock) begin
      event_type ev;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (event_q.size() == 0) begin
               $error("unexpected result beat: event_id %h", rsp_tdata);
               mismatch_count++;
            end else begin
               ev = event_q.pop_front();
               if (rsp_tdata !== ev.id) begin
                  $error("event_id: expected %h, got %h", ev.id, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tlast !== ev.last) begin
                  $error("last_of_run: expected %b, got %b", ev.last, rsp_tlast);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== ev.empty) begin
                  $error("empty_error: expected %b, got %b", ev.empty, rsp_tuser[0]);
                  mismatch_count++;
               end
               if (rsp_tuser[1] !== ev.dropped) begin
                  $error("dropped_flag: expected %b, got %b", ev.dropped, rsp_tuser[1]);
                  mismatch_count++;
               end
               if (rsp_tuser[2] !== ev.sat) begin
                  $error("time_saturated: expected %b, got %b", ev.sat, rsp_tuser[2]);
                  mismatch_count++;
               end
            end
         end
         // back-pressure: stall now and then; new stalls start only outside calm stretches
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 2) == 0) hold_left = pick_gap();
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("periodic_event_scheduler regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------
   initial begin
      int start;
      int n;
      bit drain;

      // Directed: empty table, odd kinds, extremes, ties, a full table.
      add_job(ReqRun, $urandom(), rand_period(), 7'd1, 0, 0);
      add_job(ReqRun, $urandom(), rand_period(), 7'd0, 0, 0);
      add_job(ReqSpare, $urandom(), rand_period(), 7'd5, 0, 0);
      add_job(ReqLoad, 32'h0, 24'h0, 7'd0, 0, 0);
      add_job(ReqLoad, 32'hFFFF_FFFF, 24'hFF_FFFF, 7'h7F, 0, 0);
      add_job(ReqLoad, 32'd5, 24'd3, 7'd0, 0, 0);          // same due, same id
      add_job(ReqLoad, 32'd5, 24'd3, 7'd0, 0, 0);
      add_job(ReqLoad, 32'd2, 24'd3, 7'd0, 0, 0);          // same due, smaller id
      add_job(ReqRun, 32'h0, 24'h0, 7'd10, 0, 0);
      repeat (11) add_job(ReqLoad, pick_id(), pick_period(), rand_count(), 0, 0);
      add_job(ReqLoad, 32'h1234_5678, 24'd1, 7'd0, 0, 0);  // table full: dropped
      add_job(ReqRun, $urandom(), 24'h0, 7'd64, 0, 0);
      add_job(ReqRun, $urandom(), 24'h0, 7'd127, 0, 0);
      add_job(ReqClear, $urandom(), rand_period(), 7'd3, 0, 0);
      add_job(ReqRun, 32'h0, 24'h0, 7'd1, 0, 0);           // empty, drop flag set

      // Fast phase: one source at the largest period, long runs with no idling, then a second source.
      add_job(ReqClear, 32'h0, 24'h0, 7'd0, 1, 1);
      add_job(ReqLoad, 32'hA5A5_0001, {PerW{1'b1}}, 7'd0, 0, 1);
      for (int r = 0; r < FastRuns; r++)
         add_job(ReqRun, $urandom(), rand_period(), r[0] ? 7'd127 : 7'd64, 0, 1);
      add_job(ReqLoad, 32'hA5A5_0000, {PerW{1'b1}}, 7'd0, 0, 1);
      add_job(ReqRun, 32'h0, 24'h0, 7'd40, 0, 1);

      // Random: mostly clear / load burst / runs, the rest loose beats.
      start = job_total;
      drain = 1'b1;
      while (job_total - start < RandomJobs) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 3) != 0)
               add_job(ReqClear, $urandom(), rand_period(), rand_count(), drain, 0);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 8);
            repeat (n) add_job(ReqLoad, pick_id(), pick_period(), rand_count(), 0, 0);
            repeat ($urandom_range(1, 3))
               add_job(ReqRun, $urandom(), rand_period(), pick_count(), 0, 0);
         end else begin
            add_job(2'($urandom_range(0, 3)), pick_id(), pick_period(), pick_count(),
                    drain, 0);
         end
         drain = ($urandom_range(0, 19) == 0);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (job_q.size() != 0 || req_tvalid) @(posedge clock);
      while (event_q.size() != 0) @(posedge clock);
      // let any stray beat show up before the verdict
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("periodic_event_scheduler regression: pass");
      end else begin
         $display("periodic_event_scheduler regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/pes_pkg.sv
sv/pes_ram.sv
sv/periodic_event_scheduler.sv
sv/pes_checker.sv
bench/tb.sv
